@@ sv/psa_pkg.sv @@
// shared types and codes for the physical segment allocator
package psa_pkg;

  localparam int NUM_REGIONS  = 4;
  localparam int SUB_ENTRIES  = 16;
  localparam int REG_W        = $clog2(NUM_REGIONS);
  localparam int IDX_W        = $clog2(SUB_ENTRIES);
  localparam int CNT_W        = IDX_W + 1;
  localparam int ADDR_W       = 52;
  localparam int PAGES_W      = 40;
  localparam int REFS_W       = 16;
  localparam int PAGE_SHIFT   = 12;
  localparam int MEM_DEPTH    = NUM_REGIONS * SUB_ENTRIES;
  localparam int MEM_AW       = REG_W + IDX_W;
  localparam logic [REFS_W-1:0] REFS_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    CMD_ALLOC     = 3'd0,
    CMD_FIXED     = 3'd1,
    CMD_FREE      = 3'd2,
    CMD_REMAP_INC = 3'd3,
    CMD_REMAP_DEC = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_REJECTED  = 3'd1,
    ST_BAD_ADDR  = 3'd2,
    ST_BUSY      = 3'd3,
    ST_BAD_PARAM = 3'd4,
    ST_NO_SPACE  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    CFG_R0_BASE  = 3'd0,
    CFG_R0_PAGES = 3'd1,
    CFG_R1_BASE  = 3'd2,
    CFG_R1_PAGES = 3'd3,
    CFG_R2_BASE  = 3'd4,
    CFG_R2_PAGES = 3'd5,
    CFG_R3_BASE  = 3'd6,
    CFG_R3_PAGES = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [PAGES_W-1:0] pages;
    logic [REFS_W-1:0]  refs;
  } entry_t;

endpackage

@@ sv/physical_segment_allocator.sv @@
// physical segment allocator: range tables in one entry memory, driven by a sequencer
//
// requests enter on in_valid/in_stall with command, address, page count and alignment.
// each request gives exactly one response on out_valid/out_stall: status and, for a
// successful allocate or fixed allocate, the base address of the new range.
// one request is worked at a time; in_stall is high while the sequencer is busy.
// unknown commands and a zero page count for an allocate go from idle straight to the
// done state; other requests first search the region tables in order. an allocate reads
// each entry, aligns the gap before it and checks the fit, then tries the gap after the
// last entry; an insert inside a table moves the tail entries up one at a time before the
// new entry is written. the sequencer then returns to idle before it takes the next request.
// the entry memory has one write port and one registered read port.
// the response register decouples the sides: the next request is taken while a
// response still waits, and the sequencer only holds at its end if a stalled
// response is still pending.
// config writes (cfg_we, cfg_index, cfg_wdata) set region bases and sizes; the user
// must make them while the block is idle, as the block itself does not enforce it.
// reset (rst_n low, synchronous) empties all tables and clears the region registers;
// no clearing pass is needed.
module physical_segment_allocator
  import psa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_command,
  input  logic [ADDR_W-1:0]   in_address,
  input  logic [PAGES_W-1:0]  in_page_count,
  input  logic [5:0]          in_align_log2,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_status,
  output logic [ADDR_W-1:0]   out_result_address,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [ADDR_W-1:0]   cfg_wdata
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_REG    = 13'b0000000000010,
    S_CHK    = 13'b0000000000100,
    S_RD     = 13'b0000000001000,
    S_DATA   = 13'b0000000010000,
    S_ALIGN  = 13'b0000000100000,
    S_FIT    = 13'b0000001000000,
    S_MV_RD  = 13'b0000010000000,
    S_MV_WR  = 13'b0000100000000,
    S_WR_NEW = 13'b0001000000000,
    S_DEL_RD = 13'b0010000000000,
    S_DEL_WR = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_t;

  state_t               state_r;
  logic [ADDR_W-1:0]    region_base_r  [NUM_REGIONS];
  logic [PAGES_W-1:0]   region_pages_r [NUM_REGIONS];
  logic [CNT_W-1:0]     count_r        [NUM_REGIONS];

  logic [2:0]           cmd_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [PAGES_W-1:0]   pages_r;
  logic [63:0]          mask_r;
  logic [ADDR_W:0]      req_end_r;
  logic [REG_W-1:0]     r_r;
  logic [CNT_W-1:0]     j_r;
  logic [CNT_W-1:0]     pos_r;
  logic                 pos_set_r;
  logic [ADDR_W:0]      rend_r;
  logic [ADDR_W:0]      gap_lo_r;
  logic [ADDR_W:0]      gap_hi_r;
  logic [ADDR_W:0]      ent_end_r;
  logic                 last_gap_r;
  logic [63:0]          c_r;
  logic [ADDR_W-1:0]    ins_base_r;
  logic [2:0]           res_status_r;
  logic [ADDR_W-1:0]    res_addr_r;
  logic                 out_valid_r;
  logic [2:0]           out_status_r;
  logic [ADDR_W-1:0]    out_addr_r;

  entry_t               mem [MEM_DEPTH];
  entry_t               rdata_r;
  logic                 mem_we;
  logic [MEM_AW-1:0]    mem_wa;
  entry_t               mem_wd;
  logic [MEM_AW-1:0]    rd_addr;

  entry_t               ent;
  logic [ADDR_W:0]      ent_end;
  logic [ADDR_W:0]      rend_calc;
  logic [CNT_W-1:0]     n_cur;
  logic                 last_region;
  logic [64:0]          fit_sum;
  logic                 fits;
  logic                 in_acc;

  assign in_stall           = (state_r != S_IDLE);
  assign in_acc             = in_valid && !in_stall;
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_address = out_addr_r;

  assign ent         = rdata_r;
  assign ent_end     = {1'b0, ent.base} + {1'b0, ent.pages, {PAGE_SHIFT{1'b0}}};
  assign n_cur       = count_r[r_r];
  assign last_region = (r_r == REG_W'(NUM_REGIONS - 1));
  assign rd_addr     = {r_r, j_r[IDX_W-1:0]};
  assign fit_sum     = {1'b0, c_r} + {13'b0, pages_r, {PAGE_SHIFT{1'b0}}};
  assign fits        = fit_sum <= {12'b0, gap_hi_r};

  always_comb begin
    logic [ADDR_W:0] e;
    e = {1'b0, region_base_r[r_r]} + {1'b0, region_pages_r[r_r], {PAGE_SHIFT{1'b0}}};
    rend_calc = e[ADDR_W] ? {1'b1, {ADDR_W{1'b0}}} : e;
  end

  // entry memory write port
  always_comb begin
    mem_we = 1'b0;
    mem_wa = rd_addr;
    mem_wd = rdata_r;
    case (state_r)
      S_DATA: begin
        mem_we = (cmd_r == CMD_REMAP_INC || cmd_r == CMD_REMAP_DEC) &&
                 ent.base == addr_r &&
                 ((cmd_r == CMD_REMAP_INC && ent.refs != REFS_MAX) ||
                  (cmd_r == CMD_REMAP_DEC && ent.refs != '0));
        mem_wd.refs = (cmd_r == CMD_REMAP_INC) ? ent.refs + 1'b1 : ent.refs - 1'b1;
      end
      S_MV_WR: begin
        mem_we = 1'b1;
        mem_wa = {r_r, j_r[IDX_W-1:0] + 1'b1};
      end
      S_DEL_WR: begin
        mem_we = 1'b1;
        mem_wa = {r_r, j_r[IDX_W-1:0] - 1'b1};
      end
      S_WR_NEW: begin
        mem_we = 1'b1;
        mem_wa = {r_r, pos_r[IDX_W-1:0]};
        mem_wd = '{base: ins_base_r, pages: pages_r, refs: '0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGIONS; i++) begin
        region_base_r[i]  <= '0;
        region_pages_r[i] <= '0;
        count_r[i]        <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index[0]) region_pages_r[cfg_index[2:1]] <= cfg_wdata[PAGES_W-1:0];
        else              region_base_r[cfg_index[2:1]]  <= cfg_wdata;
      end
      if (state_r == S_WR_NEW) count_r[r_r] <= count_r[r_r] + 1'b1;
      if ((state_r == S_DATA && cmd_r == CMD_FREE && ent.base == addr_r &&
           ent.refs == '0 && j_r + 1'b1 == n_cur) ||
          (state_r == S_DEL_WR && j_r + 1'b1 == n_cur))
        count_r[r_r] <= count_r[r_r] - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall)                    out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cmd_r        <= in_command;
            addr_r       <= in_address;
            pages_r      <= in_page_count;
            mask_r       <= (64'd1 << in_align_log2) - 64'd1;
            req_end_r    <= {1'b0, in_address} +
                            {1'b0, in_page_count, {PAGE_SHIFT{1'b0}}};
            r_r          <= '0;
            res_addr_r   <= '0;
            if (in_command > CMD_REMAP_DEC) begin
              res_status_r <= ST_BAD_PARAM;
              state_r      <= S_DONE;
            end else if ((in_command == CMD_ALLOC || in_command == CMD_FIXED) &&
                         in_page_count == '0) begin
              res_status_r <= ST_REJECTED;
              state_r      <= S_DONE;
            end else begin
              state_r      <= S_REG;
            end
          end
        end
        S_REG: begin
          rend_r  <= rend_calc;
          j_r     <= '0;
          state_r <= S_CHK;
        end
        S_CHK: begin
          case (cmd_r)
            CMD_ALLOC: begin
              gap_lo_r  <= {1'b0, region_base_r[r_r]};
              pos_r     <= '0;
              if (region_pages_r[r_r] < pages_r ||
                  n_cur >= CNT_W'(SUB_ENTRIES)) begin
                if (last_region) begin
                  res_status_r <= ST_NO_SPACE;
                  state_r      <= S_DONE;
                end else begin
                  r_r     <= r_r + 1'b1;
                  state_r <= S_REG;
                end
              end else if (n_cur == '0) begin
                gap_hi_r   <= rend_r;
                last_gap_r <= 1'b1;
                state_r    <= S_ALIGN;
              end else begin
                last_gap_r <= 1'b0;
                state_r    <= S_RD;
              end
            end
            CMD_FIXED: begin
              pos_r     <= n_cur;
              pos_set_r <= 1'b0;
              if (!(region_base_r[r_r] <= addr_r && req_end_r <= rend_r)) begin
                if (last_region) begin
                  res_status_r <= ST_BAD_ADDR;
                  state_r      <= S_DONE;
                end else begin
                  r_r     <= r_r + 1'b1;
                  state_r <= S_REG;
                end
              end else if (n_cur >= CNT_W'(SUB_ENTRIES)) begin
                res_status_r <= ST_REJECTED;
                state_r      <= S_DONE;
              end else begin
                ins_base_r <= addr_r;
                state_r    <= (n_cur == '0) ? S_WR_NEW : S_RD;
              end
            end
            default: begin
              // free and remap: lookup in the first region holding the address
              if (!(region_base_r[r_r] <= addr_r && {1'b0, addr_r} < rend_r)) begin
                if (last_region) begin
                  res_status_r <= ST_BAD_ADDR;
                  state_r      <= S_DONE;
                end else begin
                  r_r     <= r_r + 1'b1;
                  state_r <= S_REG;
                end
              end else if (n_cur == '0) begin
                res_status_r <= ST_BAD_ADDR;
                state_r      <= S_DONE;
              end else begin
                state_r <= S_RD;
              end
            end
          endcase
        end
        S_RD: begin
          state_r <= S_DATA;
        end
        S_DATA: begin
          case (cmd_r)
            CMD_ALLOC: begin
              gap_hi_r  <= {1'b0, ent.base};
              pos_r     <= j_r;
              ent_end_r <= ent_end;
              state_r   <= S_ALIGN;
            end
            CMD_FIXED: begin
              if ({1'b0, addr_r} < ent_end && req_end_r > {1'b0, ent.base}) begin
                res_status_r <= ST_REJECTED;
                state_r      <= S_DONE;
              end else begin
                if (!pos_set_r && ent.base > addr_r) begin
                  pos_r     <= j_r;
                  pos_set_r <= 1'b1;
                end
                if (j_r + 1'b1 == n_cur) begin
                  // insert inside the table: shift the tail up first; after the last entry, write directly
                  if (pos_set_r || ent.base > addr_r) begin
                    j_r     <= n_cur - 1'b1;
                    state_r <= S_MV_RD;
                  end else begin
                    state_r <= S_WR_NEW;
                  end
                end else begin
                  j_r     <= j_r + 1'b1;
                  state_r <= S_RD;
                end
              end
            end
            default: begin
              if (ent.base == addr_r) begin
                if (cmd_r == CMD_FREE) begin
                  if (ent.refs != '0) begin
                    res_status_r <= ST_BUSY;
                    state_r      <= S_DONE;
                  end else begin
                    res_status_r <= ST_OK;
                    j_r          <= j_r + 1'b1;
                    state_r      <= (j_r + 1'b1 != n_cur) ? S_DEL_RD : S_DONE;
                  end
                end else if (cmd_r == CMD_REMAP_INC) begin
                  res_status_r <= (ent.refs == REFS_MAX) ? ST_BUSY : ST_OK;
                  state_r      <= S_DONE;
                end else begin
                  res_status_r <= (ent.refs == '0) ? ST_BAD_PARAM : ST_OK;
                  state_r      <= S_DONE;
                end
              end else if (j_r + 1'b1 == n_cur) begin
                res_status_r <= ST_BAD_ADDR;
                state_r      <= S_DONE;
              end else begin
                j_r     <= j_r + 1'b1;
                state_r <= S_RD;
              end
            end
          endcase
        end
        S_ALIGN: begin
          c_r     <= ({11'b0, gap_lo_r} + mask_r) & ~mask_r;
          state_r <= S_FIT;
        end
        S_FIT: begin
          if (fits) begin
            ins_base_r <= c_r[ADDR_W-1:0];
            if (pos_r == n_cur) begin
              state_r <= S_WR_NEW;
            end else begin
              j_r     <= n_cur - 1'b1;
              state_r <= S_MV_RD;
            end
          end else if (last_gap_r) begin
            if (last_region) begin
              res_status_r <= ST_NO_SPACE;
              state_r      <= S_DONE;
            end else begin
              r_r     <= r_r + 1'b1;
              state_r <= S_REG;
            end
          end else begin
            gap_lo_r <= ent_end_r;
            j_r      <= j_r + 1'b1;
            if (j_r + 1'b1 == n_cur) begin
              gap_hi_r   <= rend_r;
              pos_r      <= n_cur;
              last_gap_r <= 1'b1;
              state_r    <= S_ALIGN;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_MV_RD: begin
          state_r <= S_MV_WR;
        end
        S_MV_WR: begin
          if (j_r == pos_r) begin
            state_r <= S_WR_NEW;
          end else begin
            j_r     <= j_r - 1'b1;
            state_r <= S_MV_RD;
          end
        end
        S_WR_NEW: begin
          res_status_r <= ST_OK;
          res_addr_r   <= ins_base_r;
          state_r      <= S_DONE;
        end
        S_DEL_RD: begin
          state_r <= S_DEL_WR;
        end
        S_DEL_WR: begin
          j_r <= j_r + 1'b1;
          state_r <= (j_r + 1'b1 == n_cur) ? S_DONE : S_DEL_RD;
        end
        S_DONE: begin
          // hold only while an earlier response is still stalled
          if (!out_valid_r || !out_stall) begin
            out_status_r <= res_status_r;
            out_addr_r   <= (res_status_r == ST_OK) ? res_addr_r : '0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ verif/physical_segment_allocator_tb.sv @@
// testbench for the physical segment allocator: directed and random requests checked against a predictor
module physical_segment_allocator_tb;
  import psa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] ADDR_LIMIT = 64'd1 << 52;
  localparam logic [63:0] M52 = (64'd1 << 52) - 64'd1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_command = '0;
  logic [ADDR_W-1:0] in_address = '0;
  logic [PAGES_W-1:0] in_page_count = '0;
  logic [5:0] in_align_log2 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_status;
  logic [ADDR_W-1:0] out_result_address;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [ADDR_W-1:0] cfg_wdata = '0;

  physical_segment_allocator dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  typedef struct packed {
    logic [2:0] status;
    logic [ADDR_W-1:0] addr;
  } response_t;

  // predictor state
  logic [63:0] reg_base [NUM_REGIONS];
  logic [63:0] reg_pages [NUM_REGIONS];
  logic [63:0] tbl_base [NUM_REGIONS][SUB_ENTRIES];
  logic [63:0] tbl_pages [NUM_REGIONS][SUB_ENTRIES];
  logic [15:0] tbl_refs [NUM_REGIONS][SUB_ENTRIES];
  int tbl_count [NUM_REGIONS];

  response_t expected_responses[$];
  int errors = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_cycles = 0;
  int burst_left = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic logic [63:0] region_end(input int r);
    logic [63:0] e;
    e = reg_base[r] + (reg_pages[r] << 12);
    return (e > ADDR_LIMIT) ? ADDR_LIMIT : e;
  endfunction

  function automatic void table_insert(input int r, input int pos, input logic [63:0] b,
                                       input logic [63:0] p);
    for (int k = tbl_count[r]; k > pos; k--) begin
      tbl_base[r][k] = tbl_base[r][k-1];
      tbl_pages[r][k] = tbl_pages[r][k-1];
      tbl_refs[r][k] = tbl_refs[r][k-1];
    end
    tbl_base[r][pos] = b;
    tbl_pages[r][pos] = p;
    tbl_refs[r][pos] = '0;
    tbl_count[r]++;
  endfunction

  // returns region*SUB_ENTRIES+slot, or -1
  function automatic int find_entry(input logic [63:0] a, output int r);
    r = 0;
    for (int i = 0; i < NUM_REGIONS; i++)
      if (reg_base[i] <= a && a < region_end(i)) begin
        r = i;
        for (int j = 0; j < tbl_count[i]; j++)
          if (tbl_base[i][j] == a) return i * SUB_ENTRIES + j;
        return -1;
      end
    return -1;
  endfunction

  function automatic response_t predict_response(input logic [2:0] cmd, input logic [63:0] a,
                                                 input logic [63:0] p, input logic [5:0] lg);
    response_t rsp;
    logic [63:0] size, mask, lo, hi, c, req_end;
    int r, s, j, n, pos;
    bit done;
    rsp.status = ST_BAD_PARAM;
    rsp.addr = '0;
    size = p << 12;
    case (cmd)
      CMD_ALLOC: begin
        mask = (64'd1 << lg) - 64'd1;
        rsp.status = ST_NO_SPACE;
        done = 1'b0;
        if (p == 0) rsp.status = ST_REJECTED;
        else for (r = 0; r < NUM_REGIONS && !done; r++) begin
          n = tbl_count[r];
          if (reg_pages[r] < p || n >= SUB_ENTRIES) continue;
          // gap j lies before entry j; gap n is after the last entry
          for (j = 0; j <= n && !done; j++) begin
            lo = (j == 0) ? reg_base[r] : tbl_base[r][j-1] + (tbl_pages[r][j-1] << 12);
            hi = (j == n) ? region_end(r) : tbl_base[r][j];
            c = (lo + mask) & ~mask;
            if (c + size <= hi) begin
              table_insert(r, j, c, p);
              rsp.status = ST_OK;
              rsp.addr = c[ADDR_W-1:0];
              done = 1'b1;
            end
          end
        end
      end
      CMD_FIXED: begin
        req_end = a + size;
        rsp.status = ST_BAD_ADDR;
        done = 1'b0;
        if (p == 0) rsp.status = ST_REJECTED;
        else for (r = 0; r < NUM_REGIONS && !done; r++) begin
          if (!(reg_base[r] <= a && req_end <= region_end(r))) continue;
          done = 1'b1;
          n = tbl_count[r];
          pos = n;
          rsp.status = ST_OK;
          if (n >= SUB_ENTRIES) rsp.status = ST_REJECTED;
          else for (j = 0; j < n; j++) begin
            if (a < tbl_base[r][j] + (tbl_pages[r][j] << 12) && req_end > tbl_base[r][j])
              rsp.status = ST_REJECTED;
            if (pos == n && tbl_base[r][j] > a) pos = j;
          end
          if (rsp.status == ST_OK) begin
            table_insert(r, pos, a, p);
            rsp.addr = a[ADDR_W-1:0];
          end
        end
      end
      CMD_FREE, CMD_REMAP_INC, CMD_REMAP_DEC: begin
        s = find_entry(a, r);
        if (s < 0) rsp.status = ST_BAD_ADDR;
        else begin
          j = s % SUB_ENTRIES;
          if (cmd == CMD_FREE) begin
            if (tbl_refs[r][j] != 0) rsp.status = ST_BUSY;
            else begin
              for (int k = j; k < tbl_count[r] - 1; k++) begin
                tbl_base[r][k] = tbl_base[r][k+1];
                tbl_pages[r][k] = tbl_pages[r][k+1];
                tbl_refs[r][k] = tbl_refs[r][k+1];
              end
              tbl_count[r]--;
              rsp.status = ST_OK;
            end
          end else if (cmd == CMD_REMAP_INC) begin
            if (tbl_refs[r][j] == REFS_MAX) rsp.status = ST_BUSY;
            else begin
              tbl_refs[r][j]++;
              rsp.status = ST_OK;
            end
          end else begin
            if (tbl_refs[r][j] == 0) rsp.status = ST_BAD_PARAM;
            else begin
              tbl_refs[r][j]--;
              rsp.status = ST_OK;
            end
          end
        end
      end
      default: rsp.status = ST_BAD_PARAM;
    endcase
    return rsp;
  endfunction

  // one request; waits until accepted, then predicts
  // valid stays high into the next request of a burst and drops only in a gap
  task automatic send_request(input logic [2:0] cmd, input logic [63:0] a,
                              input logic [63:0] p, input logic [5:0] lg);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_address <= a[ADDR_W-1:0];
    in_page_count <= p[PAGES_W-1:0];
    in_align_log2 <= lg;
    do @(posedge clk); while (in_stall);
    expected_responses.push_back(predict_response(cmd, a & M52, p & ((64'd1 << 40) - 1), lg));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_responses.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_idx_t idx, input logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v[ADDR_W-1:0];
    @(posedge clk);
    if (idx[0]) reg_pages[idx >> 1] = v & ((64'd1 << 40) - 1);
    else reg_base[idx >> 1] = v & M52;
  endtask

  task automatic set_regions(input logic [63:0] b0, p0, b1, p1, b2, p2, b3, p3);
    write_cfg(CFG_R0_BASE, b0);
    write_cfg(CFG_R0_PAGES, p0);
    write_cfg(CFG_R1_BASE, b1);
    write_cfg(CFG_R1_PAGES, p1);
    write_cfg(CFG_R2_BASE, b2);
    write_cfg(CFG_R2_PAGES, p2);
    write_cfg(CFG_R3_BASE, b3);
    write_cfg(CFG_R3_PAGES, p3);
    cfg_we <= 1'b0;
  endtask

  // pick an address: an existing base, one near a region's base, a region's last page or noise
  function automatic logic [63:0] pick_address();
    int r;
    r = $urandom_range(0, NUM_REGIONS - 1);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: if (tbl_count[r] > 0)
        return tbl_base[r][$urandom_range(0, tbl_count[r] - 1)];
      6: return reg_base[r] + (64'($urandom_range(0, 64)) << 12);
      7: return region_end(r) - 64'h1000;
      default: ;
    endcase
    return {$urandom, $urandom} & M52;
  endfunction

  task automatic random_requests(input int count, input int max_pages);
    logic [2:0] cmd;
    logic [63:0] a, p;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: cmd = CMD_ALLOC;
        5, 6, 7: cmd = CMD_FIXED;
        8, 9, 10, 11: cmd = CMD_FREE;
        12, 13, 14, 15: cmd = CMD_REMAP_INC;
        16, 17, 18: cmd = CMD_REMAP_DEC;
        default: cmd = 3'($urandom_range(5, 7));
      endcase
      a = pick_address();
      if ($urandom_range(0, 3) == 0) a = a + 64'h1000 * $urandom_range(0, 8);
      p = ($urandom_range(0, 40) == 0) ? {$urandom, $urandom} : $urandom_range(0, max_pages);
      send_request(cmd, a, p, 6'($urandom_range(0, 20) == 0 ? $urandom_range(0, 63)
                                                           : $urandom_range(12, 18)));
    end
  endtask

  task automatic test_directed();
    set_regions(64'h10_0000, 64, 64'h100_0000, 256, 64'h1000_0000, 16,
                M52 - 64'hF_FFFF, 64'hFF_FFFF_FFFF);
    send_request(CMD_ALLOC, 0, 0, 12);
    send_request(CMD_FIXED, 64'h10_0000, 0, 0);
    send_request(CMD_ALLOC, 0, 4, 12);
    send_request(CMD_ALLOC, 0, 1, 20);
    send_request(CMD_ALLOC, 0, 2, 63);
    send_request(CMD_ALLOC, 0, 64'hFF_FFFF_FFFF, 0);
    send_request(CMD_FIXED, 64'h10_8000, 2, 0);
    send_request(CMD_FIXED, 64'h10_9000, 2, 0);
    send_request(CMD_FIXED, 64'h5, 1, 0);
    send_request(CMD_FIXED, M52 - 64'hFFF, 1, 0);
    send_request(CMD_FIXED, M52, 1, 0);
    send_request(CMD_REMAP_DEC, 64'h10_8000, 0, 0);
    send_request(CMD_REMAP_INC, 64'h10_8000, 0, 0);
    send_request(CMD_FREE, 64'h10_8000, 0, 0);
    send_request(CMD_REMAP_DEC, 64'h10_8000, 0, 0);
    send_request(CMD_FREE, 64'h10_8000, 0, 0);
    send_request(CMD_FREE, 64'h10_8000, 0, 0);
    send_request(CMD_FREE, 64'h10_1000, 0, 0);
    send_request(3'd5, 0, 0, 0);
    send_request(3'd6, M52, 64'hFF_FFFF_FFFF, 6'h3F);
    send_request(3'd7, 0, 0, 0);
    drain();
  endtask

  // drive one entry's remap count up, try to free it, then count back past zero
  task automatic test_refs_count();
    send_request(CMD_FIXED, 64'h100_0000, 1, 0);
    for (int i = 0; i < 40; i++) send_request(CMD_REMAP_INC, 64'h100_0000, 0, 0);
    send_request(CMD_FREE, 64'h100_0000, 0, 0);
    for (int i = 0; i < 41; i++) send_request(CMD_REMAP_DEC, 64'h100_0000, 0, 0);
    send_request(CMD_FREE, 64'h100_0000, 0, 0);
    drain();
  endtask

  // small regions so tables fill and searches fail
  task automatic test_crowded();
    set_regions(64'h0, 8, 64'h8000, 20, 64'h2_0000, 0, 64'h4_0000, 40);
    random_requests(500, 4);
    drain();
  endtask

  task automatic test_roomy();
    set_regions(64'h1000_0000, 4096, 64'h2000_0000, 65536, 64'h1_0000_0000, 1 << 20,
                64'hF_0000_0000_0000, 64'hFF_FFFF_FFFF);
    random_requests(700, 300);
    drain();
  endtask

  task automatic test_long_hold();
    hold_reqs++;
    random_requests(60, 16);
    drain();
  endtask

  task automatic test_single_region();
    set_regions(64'h0, 64'hFF_FFFF_FFFF, 64'h0, 0, M52, 0, M52, 64'hFF_FFFF_FFFF);
    random_requests(500, 32);
    drain();
  endtask

  always @(posedge clk) begin
    response_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_responses.size() == 0) report("unexpected response", out_status, 0);
      else begin
        want = expected_responses.pop_front();
        if (out_status !== want.status) report("status", out_status, want.status);
        if (out_result_address !== want.addr) report("address", out_result_address, want.addr);
      end
    end
  end

  // receiver stall pattern; a requested hold keeps it stalled for a long stretch
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_cycles <= 400;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else out_stall <= ($urandom_range(0, 99) < 30) && ($time % 4000 > 1000);
  end

  initial begin
    for (int r = 0; r < NUM_REGIONS; r++) begin
      reg_base[r] = '0;
      reg_pages[r] = '0;
      tbl_count[r] = 0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_refs_count();
    test_crowded();
    test_long_hold();
    test_roomy();
    test_single_region();
    if (errors == 0) $display("physical_segment_allocator_tb: clean");
    else $display("physical_segment_allocator_tb: errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("physical_segment_allocator_tb: errors");
    $finish;
  end
endmodule
